@@ src/tpc_pkg.sv @@
package tpc_pkg;

  localparam int REGION_BITS  = 10;
  localparam int COUNT_BITS   = 32;
  localparam int BUDGET_BITS  = 24;
  localparam int ENTRY_BITS   = 10;
  localparam int USED_BITS    = 11;
  localparam int TABLE_DEPTH  = 1024;
  localparam int CMD_DEPTH    = 2;
  localparam int ADDR_BITS    = 3;
  localparam int DATA_BITS    = 32;

  localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = '1;
  localparam logic [BUDGET_BITS-1:0] COUNTER_MAX  = '1;

  // register index as seen in paddr above the byte offset
  localparam logic [ADDR_BITS-3:0] REG_EVENT_BUDGET = '0;

  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_TRACE    = 3'd3,
    ST_BUDGET   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_TRACE   = 2'd0,
    CMD_BUDGET  = 2'd1,
    CMD_UNKNOWN = 2'd2,
    CMD_PAIR    = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [REGION_BITS-1:0] region;
    logic                   region_known;
    logic                   trace_start;
    logic                   user_start;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [ENTRY_BITS-1:0]  entry_index;
    logic [REGION_BITS-1:0] from_region;
    logic [REGION_BITS-1:0] to_region;
    logic [COUNT_BITS-1:0]  pair_count;
    logic [USED_BITS-1:0]   entries_used;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic                   clear;
    logic [REGION_BITS-1:0] from_region;
    logic [REGION_BITS-1:0] to_region;
  } cmd_t;

  typedef struct packed {
    logic [REGION_BITS-1:0] from_region;
    logic [REGION_BITS-1:0] to_region;
    logic [COUNT_BITS-1:0]  count;
  } tbl_entry_t;

endpackage

@@ src/tpc_front.sv @@
module tpc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  tpc_pkg::in_item_t                   in_data,
  input  logic                                q_full,
  output logic                                q_wr,
  output tpc_pkg::cmd_t                       q_data,
  input  logic                                cfg_we,
  input  logic [tpc_pkg::BUDGET_BITS-1:0]     cfg_wdata,
  output logic [tpc_pkg::BUDGET_BITS-1:0]     budget
);

  localparam int RB = tpc_pkg::REGION_BITS;
  localparam int BB = tpc_pkg::BUDGET_BITS;

  logic [RB-1:0] prev_region_r, prev_region_nxt;
  logic          prev_known_r, prev_known_nxt;
  logic [BB-1:0] events_r, events_nxt;
  logic [BB-1:0] budget_r;
  logic [BB-1:0] ev_base, ev_inc;
  logic          accept;

  assign accept = push && !q_full;
  assign q_wr   = accept;
  assign budget = budget_r;

  // user start restarts the budget window before the trace start bump
  assign ev_base = in_data.user_start ? '0 : events_r;
  assign ev_inc  = (ev_base == tpc_pkg::COUNTER_MAX) ? ev_base : ev_base + BB'(1);

  always_comb begin
    prev_region_nxt    = prev_region_r;
    prev_known_nxt     = prev_known_r;
    events_nxt         = events_r;
    q_data.kind        = tpc_pkg::CMD_PAIR;
    q_data.clear       = in_data.user_start;
    q_data.from_region = prev_region_r;
    q_data.to_region   = in_data.region;
    if (in_data.user_start || in_data.trace_start) begin
      q_data.kind        = tpc_pkg::CMD_TRACE;
      q_data.from_region = '0;
      events_nxt         = ev_inc;
    end else if (events_r >= budget_r) begin
      q_data.kind = tpc_pkg::CMD_BUDGET;
    end else if (!prev_known_r || !in_data.region_known) begin
      q_data.kind = tpc_pkg::CMD_UNKNOWN;
    end else begin
      events_nxt = ev_inc;
    end
    if (accept) begin
      prev_region_nxt = in_data.region;
      prev_known_nxt  = in_data.region_known;
    end else begin
      events_nxt = events_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_region_r <= '0;
      prev_known_r  <= 1'b0;
      events_r      <= '0;
      budget_r      <= tpc_pkg::BUDGET_RESET;
    end else begin
      prev_region_r <= prev_region_nxt;
      prev_known_r  <= prev_known_nxt;
      events_r      <= events_nxt;
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
    end
  end

endmodule

@@ src/tpc_cmd_fifo.sv @@
module tpc_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  tpc_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output tpc_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int DEPTH = tpc_pkg::CMD_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  tpc_pkg::cmd_t   slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   level_r, level_nxt;
  logic            do_wr, do_rd;

  assign full    = (level_r == CW'(DEPTH));
  assign empty   = (level_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      level_nxt = level_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      level_nxt = level_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ src/tpc_back.sv @@
module tpc_back #(
  parameter int TABLE_DEPTH = tpc_pkg::TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  tpc_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output tpc_pkg::out_item_t out_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = tpc_pkg::ENTRY_BITS;
  localparam int UW = tpc_pkg::USED_BITS;
  localparam int CB = tpc_pkg::COUNT_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  tpc_pkg::cmd_t          cur_r, cur_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic                   ov_r, ov_nxt;
  tpc_pkg::out_item_t     od_r, od_nxt;

  tpc_pkg::tbl_entry_t    tbl_mem [TABLE_DEPTH];
  tpc_pkg::tbl_entry_t    rd_data_r;
  logic [IW-1:0]          rd_addr;
  logic                   tbl_we;
  logic [IW-1:0]          tbl_waddr;
  tpc_pkg::tbl_entry_t    tbl_wdata;

  logic                   out_free;
  logic                   match;
  logic                   last;
  logic [CB-1:0]          cnt_inc;
  logic [TW-1:0]          tot_clr;

  assign empty    = !ov_r;
  assign out_data = od_r;
  assign out_free = !ov_r || pop;

  assign match   = (rd_data_r.from_region == cur_r.from_region) &&
                   (rd_data_r.to_region == cur_r.to_region);
  assign last    = ((TW'(idx_r) + TW'(1)) == total_r);
  assign cnt_inc = (rd_data_r.count == '1) ? rd_data_r.count : rd_data_r.count + CB'(1);
  assign tot_clr = cmd.clear ? '0 : total_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    ov_nxt    = ov_r && !pop;
    od_nxt    = od_r;
    cmd_pop   = 1'b0;
    rd_addr   = '0;
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop            = 1'b1;
          cur_nxt            = cmd;
          od_nxt.entry_index = '0;
          od_nxt.from_region = cmd.from_region;
          od_nxt.to_region   = cmd.to_region;
          od_nxt.pair_count  = '0;
          od_nxt.entries_used = UW'(total_r);
          case (cmd.kind)
            tpc_pkg::CMD_PAIR: begin
              if (total_r == '0) begin
                // empty table: straight insert at the head
                tbl_we              = 1'b1;
                tbl_waddr           = '0;
                tbl_wdata.from_region = cmd.from_region;
                tbl_wdata.to_region   = cmd.to_region;
                tbl_wdata.count       = CB'(1);
                total_nxt           = TW'(1);
                ov_nxt              = 1'b1;
                od_nxt.status       = tpc_pkg::ST_INSERTED;
                od_nxt.pair_count   = CB'(1);
                od_nxt.entries_used = UW'(1);
              end else begin
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            tpc_pkg::CMD_TRACE: begin
              total_nxt           = tot_clr;
              ov_nxt              = 1'b1;
              od_nxt.status       = tpc_pkg::ST_TRACE;
              od_nxt.entries_used = UW'(tot_clr);
            end
            tpc_pkg::CMD_BUDGET: begin
              ov_nxt        = 1'b1;
              od_nxt.status = tpc_pkg::ST_BUDGET;
            end
            default: begin
              ov_nxt        = 1'b1;
              od_nxt.status = tpc_pkg::ST_UNKNOWN;
            end
          endcase
        end
      end
      S_SCAN: begin
        // rd_data_r holds entry idx_r, read in the previous cycle
        od_nxt.entry_index  = '0;
        od_nxt.from_region  = cur_r.from_region;
        od_nxt.to_region    = cur_r.to_region;
        od_nxt.pair_count   = '0;
        od_nxt.entries_used = UW'(total_r);
        if (match) begin
          tbl_we              = 1'b1;
          tbl_waddr           = idx_r;
          tbl_wdata.from_region = cur_r.from_region;
          tbl_wdata.to_region   = cur_r.to_region;
          tbl_wdata.count       = cnt_inc;
          ov_nxt              = 1'b1;
          od_nxt.status       = tpc_pkg::ST_COUNTED;
          od_nxt.entry_index  = EW'(idx_r);
          od_nxt.pair_count   = cnt_inc;
          state_nxt           = S_IDLE;
        end else if (last) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if (total_r != TW'(TABLE_DEPTH)) begin
            tbl_we              = 1'b1;
            tbl_waddr           = total_r[IW-1:0];
            tbl_wdata.from_region = cur_r.from_region;
            tbl_wdata.to_region   = cur_r.to_region;
            tbl_wdata.count       = CB'(1);
            total_nxt           = total_r + TW'(1);
            od_nxt.status       = tpc_pkg::ST_INSERTED;
            od_nxt.entry_index  = EW'(total_r);
            od_nxt.pair_count   = CB'(1);
            od_nxt.entries_used = UW'(total_r + TW'(1));
          end else begin
            od_nxt.status = tpc_pkg::ST_FULL;
          end
        end else begin
          rd_addr = idx_r + IW'(1);
          idx_nxt = idx_r + IW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    od_r  <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

endmodule

@@ src/transition_pair_counter.sv @@
// transition pair counter: counts (previous region, region) transitions per user
// input channel: queue style, an event transaction is taken when push is high and
//   full is low; events go through a two-entry command queue to the table engine
// result channel: one result per event, oldest first; out_data is valid while
//   empty is low and is taken when pop is high
// apb port: a single register, event_budget, at byte address 0; pready is tied high
// trace start, budget and unknown results need no table scan: the event is written into
//   the command queue, then the engine moves the command from the queue into the output register
// a transition scans the pair table in insertion order, one entry per cycle through
//   the table memory's single read port: a hit ends the scan at the matching entry,
//   a miss (insert or table full) reads all n pairs stored, an empty table needs no scan
// the scan sets throughput; the front keeps accepting until the command queue fills
// reset clears the queue, result register, event counter and table fill count;
//   table contents are not cleared, only entries below the fill count are read
// a stalled receiver holds the result; the engine waits for the output register to
//   drain before starting the next command, then events back up into full
module transition_pair_counter #(
  parameter int TABLE_DEPTH = tpc_pkg::TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  tpc_pkg::in_item_t                 in_data,
  output logic                              empty,
  input  logic                              pop,
  output tpc_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpc_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [tpc_pkg::DATA_BITS-1:0]     pwdata,
  output logic [tpc_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);

  localparam int BB = tpc_pkg::BUDGET_BITS;
  localparam int DB = tpc_pkg::DATA_BITS;

  tpc_pkg::cmd_t  q_wdata;
  tpc_pkg::cmd_t  q_rdata;
  logic           q_wr;
  logic           q_full;
  logic           q_empty;
  logic           q_rd;
  logic           cfg_sel;
  logic           cfg_we;
  logic [BB-1:0]  budget;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[tpc_pkg::ADDR_BITS-1:2] == tpc_pkg::REG_EVENT_BUDGET);
  assign cfg_we  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? DB'(budget) : '0;
  assign full    = q_full;

  tpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_data    (q_wdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[BB-1:0]),
    .budget    (budget)
  );

  tpc_cmd_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  tpc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_rdata),
    .cmd_pop   (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule
